@@ rtl/core/crc8rx_pkg.sv @@
// Shared types and constants for the CRC-8 typed frame receiver.
package crc8rx_pkg;
    localparam int RING_DEPTH = 256;
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_NEED     = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_CHUNK    = 3'd5;

    localparam logic [1:0] KIND_VERSION = 2'd0;
    localparam logic [1:0] KIND_REPORT  = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;
    localparam logic [1:0] KIND_STALL   = 2'd3;

    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_REPORT  = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;
    localparam logic [1:0] REG_STALL   = 2'd3;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Result item: status, kind, type, length, chunk, byte count, last.
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  frame_kind;
        logic [7:0]  frame_type_byte;
        logic [6:0]  payload_length;
        logic [63:0] payload_chunk;
        logic [3:0]  chunk_bytes;
        logic        last;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        case (idx)
            3'd0:    sig_byte = 8'h72;
            3'd1:    sig_byte = 8'h65;
            3'd2:    sig_byte = 8'h57;
            3'd3:    sig_byte = 8'h41;
            3'd4:    sig_byte = 8'h53;
            3'd5:    sig_byte = 8'h44;
            default: sig_byte = 8'h00;
        endcase
    endfunction
endpackage

@@ rtl/core/crc8rx_crc.sv @@
// Byte-wide CRC-8 update, polynomial 0x07, MSB first.
module crc8rx_crc (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);
    import crc8rx_pkg::*;
    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        o_crc = c;
    end
endmodule

@@ rtl/core/crc8_typed_frame_receiver.sv @@
// Top level: ring buffer, sequencer walking bytes through the CRC unit.
// Push: result valid in the cycle after the item is taken. Parse: check the type,
// length and CRC of the frame (and the signature of a version frame), then gather
// the payload into 8-byte chunks, one byte a cycle from the ring read port while no
// result waits; not ready while busy or while a result waits.
// Synchronous active-low reset clears pointers, count, state and config registers;
// ring contents stay undefined until written.
module crc8_typed_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] operation, [8:1] rx_byte, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // status[2:0] kind[4:3] type[12:5] len[19:13]
                                        // chunk[83:20] bytes[87:84]
    output logic        m_axis_tlast
);
    import crc8rx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_CLASS, S_CRC, S_CRCCHK, S_SIG, S_CHUNK, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0] r_ring [RING_DEPTH];
    logic [7:0] r_rd;
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [7:0] r_ver, r_rep, r_ctl, r_stl;
    logic [7:0] r_crc;
    logic [1:0] r_kind;
    logic [6:0] r_len, r_idx, r_cidx;
    logic [3:0] r_nb;
    logic [63:0] r_chunk;
    logic r_valid, r_pend;
    t_result r_res;
    logic [7:0] crc_in, crc_out;
    logic [PTR_W-1:0] rd_addr;

    function automatic t_result start_result(input logic [2:0] st);
        start_result = '0;
        start_result.status = st;
        start_result.last = 1'b1;
    endfunction

    crc8rx_crc u_crc (.i_crc(crc_in), .i_data(r_rd), .o_crc(crc_out));
    assign crc_in = (r_idx == 7'd1) ? CRC_INIT : r_crc;

    assign s_axis_tready = (r_state == S_IDLE) && !r_valid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_res.chunk_bytes, r_res.payload_chunk, r_res.payload_length,
                            r_res.frame_type_byte, r_res.frame_kind, r_res.status};
    assign m_axis_tlast  = r_res.last;

    // r_idx is the byte offset (from head) of the address issued this cycle
    always_comb begin
        rd_addr = r_head + PTR_W'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_ring[rd_addr];
        if (s_axis_tvalid && s_axis_tready && !s_axis_tdata[0]
            && r_count < CNT_W'(RING_DEPTH))
            r_ring[r_head + r_count[PTR_W-1:0]] <= s_axis_tdata[8:1];
    end

    logic [7:0] d_rep, d_ctl;
    logic in_rep, in_ctl;
    always_comb begin
        d_rep = r_rd - r_rep;
        d_ctl = r_rd - r_ctl;
        in_rep = (r_rd >= r_rep) && ({1'b0, r_rd} <= {1'b0, r_rep} + 9'h3F);
        in_ctl = (r_rd >= r_ctl) && ({1'b0, r_rd} <= {1'b0, r_ctl} + 9'h40);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_ver <= '0; r_rep <= '0; r_ctl <= '0; r_stl <= '0;
            r_idx <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_VERSION: r_ver <= i_cfg_data;
                    REG_REPORT:  r_rep <= i_cfg_data;
                    REG_CONTROL: r_ctl <= i_cfg_data;
                    REG_STALL:   r_stl <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_valid && m_axis_tready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (!s_axis_tdata[0]) begin
                            r_valid <= 1'b1;
                            if (r_count < CNT_W'(RING_DEPTH)) begin
                                r_count <= r_count + CNT_W'(1);
                                r_res <= start_result(ST_STORED);
                            end else r_res <= start_result(ST_OVERFLOW);
                        end else if (r_count == '0) begin
                            r_valid <= 1'b1;
                            r_res <= start_result(ST_NEED);
                        end else begin
                            r_res <= start_result(ST_NEED);
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: r_state <= S_CLASS;   // head byte read in flight
                S_CLASS: begin
                    r_res.frame_type_byte <= r_rd;
                    if (r_rd == r_ver) begin
                        r_kind <= KIND_VERSION; r_len <= 7'd6;
                    end else if (in_rep) begin
                        r_kind <= KIND_REPORT; r_len <= 7'(d_rep) + 7'd1;
                    end else if (in_ctl) begin
                        r_kind <= KIND_CONTROL; r_len <= 7'(d_ctl) + 7'd9;
                    end else if (r_rd == r_stl) begin
                        r_kind <= KIND_STALL; r_len <= 7'd9;
                    end else r_kind <= KIND_VERSION;
                    if (!(r_rd == r_ver || in_rep || in_ctl || r_rd == r_stl)) begin
                        r_res.status <= ST_UNKNOWN;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                        r_head <= r_head + PTR_W'(1);
                        r_count <= r_count - CNT_W'(1);
                    end else begin
                        r_state <= S_CRC;
                        r_crc <= CRC_INIT;
                        r_pend <= 1'b1;
                    end
                end
                S_CRC: begin
                    // first cycle: length known, check completeness
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_res.frame_kind <= r_kind;
                        r_res.payload_length <= r_len;
                        if (r_count < CNT_W'(r_len) + CNT_W'(2)) begin
                            r_res.status <= ST_NEED;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= 7'd1;
                        end
                    end else begin
                        // r_rd holds the byte at r_idx-1; the type byte starts from init
                        r_crc <= crc_out;
                        if (r_idx == r_len + 7'd1) r_state <= S_CRCCHK;
                        else r_idx <= r_idx + 7'd1;
                    end
                end
                S_CRCCHK: begin
                    // r_rd = crc byte at len+1; r_crc covers payload up to len
                    if (r_crc != r_rd) begin
                        r_res.status <= ST_BAD_CRC;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                        r_head <= r_head + PTR_W'(1);
                        r_count <= r_count - CNT_W'(1);
                    end else begin
                        r_idx <= 7'd1;
                        r_cidx <= '0;
                        r_state <= (r_kind == KIND_VERSION) ? S_SIG : S_CHUNK;
                        r_chunk <= '0;
                        r_nb <= '0;
                        r_pend <= 1'b1;
                    end
                end
                S_SIG: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_idx <= 7'd2;
                    end else begin
                        if (r_rd != sig_byte(3'(r_idx - 7'd2))) begin
                            r_res.status <= ST_UNKNOWN;
                            r_res.frame_kind <= KIND_VERSION;
                            r_res.payload_length <= '0;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                            r_head <= r_head + PTR_W'(1);
                            r_count <= r_count - CNT_W'(1);
                        end else if (r_idx == 7'd7) begin
                            r_idx <= 7'd1;
                            r_state <= S_CHUNK;
                            r_pend <= 1'b1;
                        end else r_idx <= r_idx + 7'd1;
                    end
                end
                S_CHUNK: begin
                    // hold the read address until the previous chunk has gone
                    if (r_pend) begin
                        if (!r_valid) begin
                            r_pend <= 1'b0;
                            r_idx <= r_idx + 7'd1;
                        end
                    end else if (!r_valid) begin
                        r_chunk[8*r_nb[2:0] +: 8] <= r_rd;
                        r_nb <= r_nb + 4'd1;
                        r_cidx <= r_cidx + 7'd1;
                        if (r_cidx + 7'd1 == r_len || r_nb == 4'd7) begin
                            r_state <= S_OUT;
                        end else r_idx <= r_idx + 7'd1;
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_res.status <= ST_CHUNK;
                        r_res.payload_chunk <= r_chunk;
                        r_res.chunk_bytes <= r_nb;
                        r_res.last <= (r_cidx == r_len);
                        r_valid <= 1'b1;
                        r_chunk <= '0;
                        r_nb <= '0;
                        if (r_cidx == r_len) begin
                            r_state <= S_IDLE;
                            r_head <= r_head + PTR_W'(r_len) + PTR_W'(2);
                            r_count <= r_count - CNT_W'(r_len) - CNT_W'(2);
                        end else begin
                            r_state <= S_CHUNK;
                            r_pend <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH)) else $error("ring count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status == ST_CHUNK) |-> (r_res.chunk_bytes != 4'd0))
        else $error("empty chunk");
`endif
endmodule

@@ sim/crc8_typed_frame_receiver_tb.sv @@
// Testbench for the CRC-8 typed frame receiver: random frames, scoreboard check.
module crc8_typed_frame_receiver_tb;
    import crc8rx_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;

    // Expected-result store and byte-ring predictor of the receiver.
    class frame_scoreboard;
        logic [7:0] ring_bytes [RING_DEPTH];
        int         head_idx;
        int         fill;
        logic [7:0] version_code;
        logic [7:0] report_base;
        logic [7:0] control_base;
        logic [7:0] stall_code;
        t_result    expected_results [$];
        int         errors;

        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
            logic [7:0] c;
            c = crc ^ data;
            for (int b = 0; b < 8; b++)
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                REG_VERSION: version_code = v;
                REG_REPORT:  report_base  = v;
                REG_CONTROL: control_base = v;
                default:     stall_code   = v;
            endcase
        endfunction

        function void add_result(logic [2:0] st, logic [1:0] kind, logic [7:0] ty,
                                 logic [6:0] len, logic [63:0] chunk,
                                 logic [3:0] nb, logic lst);
            t_result r;
            r.status = st;
            r.frame_kind = kind;
            r.frame_type_byte = ty;
            r.payload_length = len;
            r.payload_chunk = chunk;
            r.chunk_bytes = nb;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function logic [7:0] at(int off);
            return ring_bytes[(head_idx + off) % RING_DEPTH];
        endfunction

        function void drop_head();
            head_idx = (head_idx + 1) % RING_DEPTH;
            fill--;
        endfunction

        function void note_item(logic op, logic [7:0] b);
            int         ti, len, n, cnt;
            logic [1:0] kind;
            logic [7:0] crc;
            logic [63:0] chunk;
            if (op == 1'b0) begin
                if (fill >= RING_DEPTH) begin
                    add_result(ST_OVERFLOW, 0, 0, 0, 0, 0, 1);
                end else begin
                    ring_bytes[(head_idx + fill) % RING_DEPTH] = b;
                    fill++;
                    add_result(ST_STORED, 0, 0, 0, 0, 0, 1);
                end
                return;
            end
            if (fill == 0) begin
                add_result(ST_NEED, 0, 0, 0, 0, 0, 1);
                return;
            end
            ti = at(0);
            if (ti == version_code) begin
                kind = KIND_VERSION; len = 6;
            end else if (ti >= report_base && ti <= report_base + 63) begin
                kind = KIND_REPORT; len = ti - report_base + 1;
            end else if (ti >= control_base && ti <= control_base + 64) begin
                kind = KIND_CONTROL; len = ti - control_base + 9;
            end else if (ti == stall_code) begin
                kind = KIND_STALL; len = 9;
            end else begin
                add_result(ST_UNKNOWN, 0, 8'(ti), 0, 0, 0, 1);
                drop_head();
                return;
            end
            if (fill < len + 2) begin
                add_result(ST_NEED, kind, 8'(ti), 7'(len), 0, 0, 1);
                return;
            end
            crc = crc_step(CRC_INIT, 8'(ti));
            for (int i = 0; i < len; i++)
                crc = crc_step(crc, at(1 + i));
            if (crc != at(1 + len)) begin
                add_result(ST_BAD_CRC, kind, 8'(ti), 7'(len), 0, 0, 1);
                drop_head();
                return;
            end
            if (kind == KIND_VERSION) begin
                if ({at(1), at(2), at(3), at(4), at(5), at(6)} != 48'h726557415344) begin
                    add_result(ST_UNKNOWN, 0, 8'(ti), 0, 0, 0, 1);
                    drop_head();
                    return;
                end
            end
            n = (len + 7) / 8;
            for (int k = 0; k < n; k++) begin
                cnt = (len - k * 8 > 8) ? 8 : len - k * 8;
                chunk = '0;
                for (int i = 0; i < cnt; i++)
                    chunk[8*i +: 8] = at(1 + k * 8 + i);
                add_result(ST_CHUNK, kind, 8'(ti), 7'(len), chunk, 4'(cnt), k + 1 == n);
            end
            head_idx = (head_idx + len + 2) % RING_DEPTH;
            fill -= len + 2;
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_results.size() == 0) begin
                $error("unexpected result item: status %0d", got.status);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("frame_kind", e.frame_kind, got.frame_kind);
            compare_field("frame_type_byte", e.frame_type_byte, got.frame_type_byte);
            compare_field("payload_length", e.payload_length, got.payload_length);
            compare_field("payload_chunk", e.payload_chunk, got.payload_chunk);
            compare_field("chunk_bytes", e.chunk_bytes, got.chunk_bytes);
            compare_field("last", e.last, got.last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    frame_scoreboard sb = new();
    bit          quiet;
    int          stall_left = 0;
    int          idle_cycles = 0;
    logic [7:0]  frame_bytes [$];

    crc8_typed_frame_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Result side: random stalls, unpack and check on every accepted item.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[2:0];
            got.frame_kind = m_axis_tdata[4:3];
            got.frame_type_byte = m_axis_tdata[12:5];
            got.payload_length = m_axis_tdata[19:13];
            got.payload_chunk = m_axis_tdata[83:20];
            got.chunk_bytes = m_axis_tdata[87:84];
            got.last = m_axis_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, b, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, b);
        @(negedge i_clk);
    endtask

    task automatic push_byte(logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic parse_head();
        send_item(1'b1, 8'($urandom));
    endtask

    // Drop valid and hold off until every expected item has come, then pause.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [7:0] ver, logic [7:0] rep, logic [7:0] ctl,
                             logic [7:0] stl);
        write_reg(REG_VERSION, ver);
        write_reg(REG_REPORT, rep);
        write_reg(REG_CONTROL, ctl);
        write_reg(REG_STALL, stl);
    endtask

    // Build type, payload and CRC into frame_bytes; corrupt flips the CRC.
    task automatic build_frame(logic [7:0] ty, int len, bit signature, bit corrupt);
        logic [7:0] crc;
        logic [7:0] sig [6];
        sig = '{8'h72, 8'h65, 8'h57, 8'h41, 8'h53, 8'h44};
        frame_bytes.delete();
        frame_bytes.push_back(ty);
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(signature ? sig[i] : 8'($urandom));
        crc = CRC_INIT;
        foreach (frame_bytes[i]) crc = frame_scoreboard::crc_step(crc, frame_bytes[i]);
        frame_bytes.push_back(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
    endtask

    task automatic push_frame();
        foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
    endtask

    // One random frame against the current settings, mostly well formed.
    task automatic random_frame();
        int r, off, len;
        logic [7:0] ty;
        bit bad;
        r = $urandom_range(0, 99);
        bad = ($urandom_range(0, 99) < 15);
        off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 10);
        if (r < 15) begin
            ty = sb.version_code; len = 6;
        end else if (r < 50) begin
            off = (off > 63) ? 63 : off;
            if (sb.report_base + off > 255) off = 255 - sb.report_base;
            ty = 8'(sb.report_base + off); len = off + 1;
        end else if (r < 80) begin
            if (sb.control_base + off > 255) off = 255 - sb.control_base;
            ty = 8'(sb.control_base + off); len = off + 9;
        end else if (r < 92) begin
            ty = sb.stall_code; len = 9;
        end else begin
            ty = 8'($urandom); len = $urandom_range(0, 4);
        end
        build_frame(ty, len, r < 12, bad);
        if ($urandom_range(0, 9) == 0) begin
            // parse part way through to see the wait case
            for (int i = 0; i < frame_bytes.size() / 2; i++) push_byte(frame_bytes[i]);
            parse_head();
            for (int i = frame_bytes.size() / 2; i < frame_bytes.size(); i++)
                push_byte(frame_bytes[i]);
        end else begin
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom));
            push_frame();
        end
        repeat ($urandom_range(1, 2)) parse_head();
    endtask

    task automatic empty_ring();
        int guard;
        guard = 0;
        while (sb.fill > 0 && guard < 400) begin
            parse_head();
            guard++;
        end
    endtask

    initial begin
        quiet = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty ring, version and report frames, signature miss, bad CRC, unknown, waiting.
        configure(8'h10, 8'h20, 8'h70, 8'hC0);
        parse_head();
        build_frame(8'h10, 6, 1'b1, 1'b0); push_frame(); parse_head();
        build_frame(8'h10, 6, 1'b0, 1'b0); push_frame(); parse_head();
        empty_ring();
        build_frame(8'h20, 1, 1'b0, 1'b0); push_frame(); parse_head();
        build_frame(8'h22, 3, 1'b0, 1'b1); push_frame(); parse_head();
        empty_ring();
        push_byte(8'hFF); parse_head();
        push_byte(8'h70); parse_head();
        build_frame(8'hC0, 9, 1'b0, 1'b0);
        frame_bytes.pop_front();
        push_frame(); parse_head();
        push_byte(8'h00);
        empty_ring();
        drain();

        // Random phases over a few settings, extremes included.
        for (int phase = 0; phase < 3; phase++) begin
            quiet = (phase == 2);
            case (phase)
                0: configure(8'h00, 8'h00, 8'h00, 8'h00);
                1: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: configure(8'h05, 8'h40, 8'h80, 8'hD0);
            endcase
            random_frame();
            empty_ring();
            drain();
        end

        s_axis_tvalid <= 1'b0;
        repeat (200) @(posedge i_clk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected result items never arrived", sb.expected_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/crc8rx_pkg.sv
rtl/core/crc8rx_crc.sv
rtl/core/crc8_typed_frame_receiver.sv
sim/crc8_typed_frame_receiver_tb.sv
